// ===== rtl/nls_pkg.sv =====
// Shared types and constants for the number literal scanner.
// Used by nls_step and number_literal_scanner_top; no dependencies.
package nls_pkg;

	// scan state, one-hot
	typedef enum logic [6:0] {
		MODE_IDLE = 7'b0000001,
		MODE_ZERO = 7'b0000010,
		MODE_DEC  = 7'b0000100,
		MODE_BIN  = 7'b0001000,
		MODE_OCT  = 7'b0010000,
		MODE_HEX  = 7'b0100000,
		MODE_FRAC = 7'b1000000
	} mode_t;

	typedef enum logic [2:0] {
		KIND_DEC   = 3'd0,
		KIND_BIN   = 3'd1,
		KIND_OCT   = 3'd2,
		KIND_HEX   = 3'd3,
		KIND_FLOAT = 3'd4
	} kind_t;

	localparam int INT_W   = 64;
	localparam int FRAC_W  = 32;
	localparam int LEN_W   = 8;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// fraction digit weights: enough steps for the widest fraction to decay to zero
	localparam int WEIGHT_STEPS = 20;
	localparam int WIDX_W       = $clog2(WEIGHT_STEPS);
	localparam logic [WIDX_W-1:0] WEIGHT_LAST = WIDX_W'(WEIGHT_STEPS - 1);

	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_1   = 8'h31;
	localparam logic [7:0] CH_7   = 8'h37;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_UB  = 8'h42;
	localparam logic [7:0] CH_LB  = 8'h62;
	localparam logic [7:0] CH_UO  = 8'h4F;
	localparam logic [7:0] CH_LO  = 8'h6F;
	localparam logic [7:0] CH_UX  = 8'h58;
	localparam logic [7:0] CH_LX  = 8'h78;

	typedef struct packed {
		logic              token_valid;
		logic              consumed;
		logic [INT_W-1:0]  int_value;
		logic [FRAC_W-1:0] frac_value;
		logic [2:0]        kind;
		logic [LEN_W-1:0]  length;
	} result_t;

endpackage

// ===== rtl/nls_step.sv =====
// One character step of the scanner: next state and result for one item.
// Purely combinational; depends on nls_pkg.
module nls_step #(
	parameter int FRAC_BITS = 32
) (
	input  nls_pkg::mode_t                   mode_q,
	input  logic [nls_pkg::INT_W-1:0]        accum_q,
	input  logic [FRAC_BITS-1:0]             frac_q,
	input  logic [nls_pkg::WIDX_W-1:0]       widx_q,
	input  logic [nls_pkg::LEN_W-1:0]        count_q,
	input  logic [7:0]                       ch,
	input  logic                             begin_req,
	output nls_pkg::mode_t                   mode_d,
	output logic [nls_pkg::INT_W-1:0]        accum_d,
	output logic [FRAC_BITS-1:0]             frac_d,
	output logic [nls_pkg::WIDX_W-1:0]       widx_d,
	output logic [nls_pkg::LEN_W-1:0]        count_d,
	output nls_pkg::result_t                 res
);

	localparam logic [63:0] W0 = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;

	logic [FRAC_BITS-1:0] weight_tab [nls_pkg::WEIGHT_STEPS];

	// weight after k fraction digits is floor(W0 / 10^k)
	for (genvar k = 0; k < nls_pkg::WEIGHT_STEPS; k++) begin : g_weight
		localparam logic [63:0] POW = 64'd10 ** k;
		localparam logic [63:0] WK  = W0 / POW;
		assign weight_tab[k] = WK[FRAC_BITS-1:0];
	end

	logic                      is_dec, is_bin, is_oct, is_lhex, is_uhex;
	logic [3:0]                dig, hex_dig;
	logic [nls_pkg::INT_W-1:0] dec_next;
	logic [FRAC_BITS+3:0]      prod;
	logic [FRAC_BITS+4:0]      fsum;
	logic [FRAC_BITS-1:0]      frac_next;
	logic [FRAC_BITS+31:0]     frac_ext;
	logic [nls_pkg::LEN_W-1:0] count_inc;

	assign is_dec  = (ch >= nls_pkg::CH_0) && (ch <= nls_pkg::CH_9);
	assign is_bin  = (ch == nls_pkg::CH_0) || (ch == nls_pkg::CH_1);
	assign is_oct  = (ch >= nls_pkg::CH_0) && (ch <= nls_pkg::CH_7);
	assign is_lhex = (ch >= nls_pkg::CH_LA) && (ch <= nls_pkg::CH_LF);
	assign is_uhex = (ch >= nls_pkg::CH_UA) && (ch <= nls_pkg::CH_UF);
	assign dig     = ch[3:0];
	// letters a..f / A..F have low nibble 1..6
	assign hex_dig = is_dec ? ch[3:0] : ch[3:0] + 4'd9;

	assign dec_next  = (accum_q << 3) + (accum_q << 1) + {60'd0, dig};
	assign prod      = weight_tab[widx_q] * dig;
	assign fsum      = {5'd0, frac_q} + {1'b0, prod};
	assign frac_next = (fsum[FRAC_BITS+4:FRAC_BITS] != '0) ? '1 : fsum[FRAC_BITS-1:0];
	assign frac_ext  = {32'd0, frac_q};
	assign count_inc = (count_q == nls_pkg::LEN_MAX) ? count_q : count_q + 1'b1;

	always_comb begin
		logic emit;
		logic [2:0] ek;
		emit    = 1'b0;
		ek      = nls_pkg::KIND_DEC;
		mode_d  = mode_q;
		accum_d = accum_q;
		frac_d  = frac_q;
		widx_d  = widx_q;
		count_d = count_q;
		res     = '0;
		case (mode_q)
			nls_pkg::MODE_ZERO: begin
				if (ch == nls_pkg::CH_LB || ch == nls_pkg::CH_UB) begin
					mode_d = nls_pkg::MODE_BIN;
				end else if (ch == nls_pkg::CH_LO || ch == nls_pkg::CH_UO) begin
					mode_d = nls_pkg::MODE_OCT;
				end else if (ch == nls_pkg::CH_LX || ch == nls_pkg::CH_UX) begin
					mode_d = nls_pkg::MODE_HEX;
				end else if (ch == nls_pkg::CH_DOT) begin
					mode_d = nls_pkg::MODE_FRAC;
					frac_d = '0;
					widx_d = '0;
				end else begin
					emit = 1'b1;
				end
			end
			nls_pkg::MODE_DEC: begin
				if (is_dec) begin
					accum_d = dec_next;
				end else if (ch == nls_pkg::CH_DOT) begin
					mode_d = nls_pkg::MODE_FRAC;
					frac_d = '0;
					widx_d = '0;
				end else begin
					emit = 1'b1;
				end
			end
			nls_pkg::MODE_BIN: begin
				ek = nls_pkg::KIND_BIN;
				if (is_bin) accum_d = {accum_q[62:0], dig[0]};
				else emit = 1'b1;
			end
			nls_pkg::MODE_OCT: begin
				ek = nls_pkg::KIND_OCT;
				if (is_oct) accum_d = {accum_q[60:0], dig[2:0]};
				else emit = 1'b1;
			end
			nls_pkg::MODE_HEX: begin
				ek = nls_pkg::KIND_HEX;
				if (is_dec || is_lhex || is_uhex) accum_d = {accum_q[59:0], hex_dig};
				else emit = 1'b1;
			end
			nls_pkg::MODE_FRAC: begin
				ek = nls_pkg::KIND_FLOAT;
				if (is_dec) begin
					frac_d = frac_next;
					widx_d = (widx_q == nls_pkg::WEIGHT_LAST) ? widx_q : widx_q + 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
				mode_d = nls_pkg::MODE_IDLE;
				if (begin_req && is_dec) begin
					accum_d      = {60'd0, dig};
					frac_d       = '0;
					widx_d       = '0;
					count_d      = 8'd1;
					mode_d       = (ch == nls_pkg::CH_0) ? nls_pkg::MODE_ZERO
						: nls_pkg::MODE_DEC;
					res.consumed = 1'b1;
				end
			end
		endcase

		if (mode_q != nls_pkg::MODE_IDLE) begin
			if (emit) begin
				mode_d          = nls_pkg::MODE_IDLE;
				res.token_valid = 1'b1;
				res.int_value   = accum_q;
				res.frac_value  = (ek == nls_pkg::KIND_FLOAT) ? frac_ext[31:0] : '0;
				res.kind        = ek;
				res.length      = count_q;
			end else begin
				count_d      = count_inc;
				res.consumed = 1'b1;
			end
		end
	end

endmodule

// ===== rtl/number_literal_scanner_top.sv =====
// Number literal scanner, top level: input register, scan state, result register.
// Depends on nls_pkg and nls_step.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  item     | item_valid / item_ready    | ch, begin_req
//  result   | result_valid / result_ready| token_valid, consumed, int_value,
//           |                            | frac_value, kind, length
//
// One result per character. Throughput is one character per cycle while the result is not
// stalled; each item passes from the input register through the scan step into the
// result register. The step's critical path is the 64-bit times-ten add or the
// fraction weight-by-digit product and saturating add.
// Reset clears the scan state to idle. A stalled result holds the input register,
// which in turn drops item_ready.
module number_literal_scanner_top #(
	parameter int FRAC_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [7:0]                  ch,
	input  logic                        begin_req,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        token_valid,
	output logic                        consumed,
	output logic [nls_pkg::INT_W-1:0]   int_value,
	output logic [nls_pkg::FRAC_W-1:0]  frac_value,
	output logic [2:0]                  kind,
	output logic [nls_pkg::LEN_W-1:0]   length
);

	localparam logic [63:0] W0 = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;

	logic                        valid_s1;
	logic [7:0]                  ch_s1;
	logic                        begin_s1;
	logic                        adv_s1;

	nls_pkg::mode_t              mode_q, mode_d;
	logic [nls_pkg::INT_W-1:0]   accum_q, accum_d;
	logic [FRAC_BITS-1:0]        frac_q, frac_d;
	logic [nls_pkg::WIDX_W-1:0]  widx_q, widx_d;
	logic [nls_pkg::LEN_W-1:0]   count_q, count_d;
	nls_pkg::result_t            res, result_q;
	logic                        result_valid_q;

	assign adv_s1     = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			ch_s1    <= ch;
			begin_s1 <= begin_req;
		end
	end

	nls_step #(
		.FRAC_BITS(FRAC_BITS)
	) u_step (
		.mode_q   (mode_q),
		.accum_q  (accum_q),
		.frac_q   (frac_q),
		.widx_q   (widx_q),
		.count_q  (count_q),
		.ch       (ch_s1),
		.begin_req(begin_s1),
		.mode_d   (mode_d),
		.accum_d  (accum_d),
		.frac_d   (frac_d),
		.widx_d   (widx_d),
		.count_d  (count_d),
		.res      (res)
	);

	// scan state moves only when the character's result is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= nls_pkg::MODE_IDLE;
			accum_q <= '0;
			frac_q  <= '0;
			widx_q  <= '0;
			count_q <= '0;
		end else if (adv_s1) begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
			frac_q  <= frac_d;
			widx_q  <= widx_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign token_valid  = result_q.token_valid;
	assign consumed     = result_q.consumed;
	assign int_value    = result_q.int_value;
	assign frac_value   = result_q.frac_value;
	assign kind         = result_q.kind;
	assign length       = result_q.length;

	// a token always returns the scanner to idle
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res.token_valid |=> mode_q == nls_pkg::MODE_IDLE)
		else $error("scanner not idle after token");

	// a character is either part of the literal or ends it, never both
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(result_q.token_valid && result_q.consumed))
		else $error("token and consumed both set");

	// fraction only reported for floating tokens
	a_frac_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.kind != nls_pkg::KIND_FLOAT |-> result_q.frac_value == '0)
		else $error("fraction on integer token");

	// length steps by one per consumed character while scanning, saturating
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res.consumed && mode_q != nls_pkg::MODE_IDLE |=>
		count_q == nls_pkg::LEN_MAX || count_q == $past(count_q) + 1'b1)
		else $error("length step wrong");

	// at each literal start the fraction state is cleared; the weight table starts at the rounded tenth
	a_weight0: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && mode_q == nls_pkg::MODE_IDLE && res.consumed |=> widx_q == '0
		&& frac_q == '0 && W0 != 64'd0)
		else $error("fraction state not cleared at literal start");

endmodule
